[hw/rtl/ssbf_pkg.sv]
// ssbf_pkg: shared types, constants and helpers for the start/stop bit framer.
// Used by ssbf_pack, start_stop_bit_framer and ssbf_checker. No dependencies.
`timescale 1ns / 1ps

package ssbf_pkg;

    localparam int FRAME_BITS   = 10;
    localparam int MAX_PENDING  = 7;
    localparam int PEND_W       = 7;
    localparam int CNT_W        = 3;
    localparam int ACC_W        = 24;
    localparam int MAX_RESULTS  = 3;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [APB_AW-1:0] ADDR_PAD_BIT = 3'h0;
    localparam logic              PAD_BIT_RST  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        logic [1:0]                  count;
        logic [PEND_W-1:0]           pend_bits;
        logic [CNT_W-1:0]            pend_count;
    } pack_res_t;

    function automatic logic [7:0] reverse_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

[hw/rtl/ssbf_pack.sv]
// ssbf_pack: frames one byte and packs it with the leftover bits into up to
// three output bytes; also gives the new leftover bits. Depends on ssbf_pkg.
`timescale 1ns / 1ps

module ssbf_pack import ssbf_pkg::*; (
    input  in_item_t          item,
    input  logic [PEND_W-1:0] pend_bits,
    input  logic [CNT_W-1:0]  pend_count,
    input  logic              pad_bit,
    output pack_res_t         res
);

    logic [PEND_W-1:0]     held;
    logic [FRAME_BITS-1:0] frame;
    logic [ACC_W-1:0]      acc;
    logic [ACC_W-1:0]      aligned;
    logic [4:0]            n;
    logic [4:0]            shamt;
    logic [1:0]            nfull;
    logic [2:0]            rem;
    logic                  has_flush;
    logic [7:0]            pad_mask;
    logic [7:0]            flush_byte;
    logic [7:0]            keep_mask;
    logic [1:0]            cnt;

    always_comb begin
        held      = pend_bits & PEND_W'((8'h01 << pend_count) - 8'h01);
        frame     = {1'b0, reverse_byte(item.data_byte), 1'b1};
        acc       = {7'b0, held, frame};
        n         = {2'b00, pend_count} + 5'(FRAME_BITS);
        shamt     = 5'(ACC_W) - n;
        aligned   = acc << shamt;
        nfull     = n[4] ? 2'd2 : 2'd1;
        rem       = n[2:0];
        has_flush = item.last_byte && (rem != 3'd0);
        pad_mask  = pad_bit ? (8'hFF >> rem) : 8'h00;
        flush_byte = (n[4] ? aligned[7:0] : aligned[15:8]) | pad_mask;
        cnt       = nfull + {1'b0, has_flush};

        res.items[0].out_byte = aligned[23:16];
        res.items[1].out_byte = n[4] ? aligned[15:8] : flush_byte;
        res.items[2].out_byte = flush_byte;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res.items[i].out_last = item.last_byte && (2'(i) == cnt - 2'd1);
        end
        res.count = cnt;

        keep_mask = (8'h01 << rem) - 8'h01;
        if (item.last_byte) begin
            res.pend_bits  = '0;
            res.pend_count = '0;
        end else begin
            res.pend_bits  = acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
            res.pend_count = rem;
        end
    end

endmodule

[hw/rtl/start_stop_bit_framer.sv]
// start_stop_bit_framer: top level; input register, leftover-bit state,
// three-byte output buffer and APB register. Depends on ssbf_pkg, ssbf_pack.
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+---------------------------
//  input    | s_valid s_ready s_data (in_item_t)      | one data byte per request
//  output   | m_valid m_ready m_data (out_item_t)     | one packed byte per request
//  config   | psel penable pwrite paddr pwdata prdata | pad_bit at address 0
//
// An accepted byte waits in the input register and is packed into the output buffer
// once that is empty or handing over its final byte; a new request is taken in the
// same cycle. A byte passes through the input register and then the output buffer;
// each input byte gives one to three output bytes (1.25 on average).
// Synchronous active-low reset clears control state, not data regs; pad_bit resets to 1.
// Stalls on m_ready hold the buffer and, once the input register fills, s_ready.
`timescale 1ns / 1ps

module start_stop_bit_framer import ssbf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic              pad_reg, pad_next;
    in_item_t          in_item_reg, in_item_next;
    logic              in_full_reg, in_full_next;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]  pend_count_reg, pend_count_next;
    out_item_t [MAX_RESULTS-1:0] buf_reg, buf_next;
    logic [1:0]        left_reg, left_next;

    pack_res_t res;
    logic      accept;
    logic      pop;
    logic      xfer;

    ssbf_pack u_pack (
        .item       (in_item_reg),
        .pend_bits  (pend_bits_reg),
        .pend_count (pend_count_reg),
        .pad_bit    (pad_reg),
        .res        (res)
    );

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_PAD_BIT) ? {{(APB_DW-1){1'b0}}, pad_reg} : '0;
    assign s_ready = !in_full_reg || xfer;
    assign m_valid = (left_reg != 2'd0);
    assign m_data  = buf_reg[0];

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;
    assign xfer   = in_full_reg && ((left_reg == 2'd0) || ((left_reg == 2'd1) && m_ready));

    always_comb begin
        pad_next = pad_reg;
        if (psel && penable && pwrite && pready && (paddr[APB_AW-1:2] == 1'b0)) begin
            pad_next = pwdata[0];
        end

        in_item_next = in_item_reg;
        in_full_next = in_full_reg;
        if (xfer) begin
            in_full_next = 1'b0;
        end
        if (accept) begin
            in_item_next = s_data;
            in_full_next = 1'b1;
        end

        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        buf_next        = buf_reg;
        left_next       = left_reg;
        if (xfer) begin
            pend_bits_next  = res.pend_bits;
            pend_count_next = res.pend_count;
            buf_next        = res.items;
            left_next       = res.count;
        end else if (pop) begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            left_next   = left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg        <= PAD_BIT_RST;
            in_full_reg    <= 1'b0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            left_reg       <= 2'd0;
        end else begin
            pad_reg        <= pad_next;
            in_full_reg    <= in_full_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        buf_reg     <= buf_next;
    end

endmodule

[hw/rtl/ssbf_checker.sv]
// ssbf_checker: port-level assertions for start_stop_bit_framer, with bind.
// Depends on ssbf_pkg.
`timescale 1ns / 1ps

module ssbf_checker import ssbf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input request refused with output buffer empty");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output request changed");

    a_drop_only_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("output request dropped without being taken");

endmodule

bind start_stop_bit_framer ssbf_checker u_ssbf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for start_stop_bit_framer. Byte buffers go through the
// framer and each packed output byte is checked against a local bit packer.
// Depends on ssbf_pkg and the framer RTL.

module tb;
    import ssbf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    out_item_t         packed_q[$];
    out_item_t         want_item;
    logic [6:0]        held_bits  = '0;
    int                held_count = 0;
    logic              pad_cfg    = PAD_BIT_RST;
    logic              burst_mode = 1'b0;
    int                mismatches = 0;
    int                idle_cycles = 0;

    start_stop_bit_framer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // frame is start 0, data LSB first, stop 1; bytes packed earliest bit in bit 7
    task automatic pack_frame(input in_item_t item);
        logic [16:0] acc;
        logic [9:0]  frame;
        logic [7:0]  fill;
        out_item_t   res;
        int          n;
        int          k;
        frame[9] = 1'b0;
        for (k = 0; k < 8; k++) begin
            frame[8-k] = item.data_byte[k];
        end
        frame[0] = 1'b1;
        acc = (17'(held_bits) << FRAME_BITS) | 17'(frame);
        n = held_count + FRAME_BITS;
        while (n >= 8) begin
            n -= 8;
            res.out_byte = 8'(acc >> n);
            res.out_last = 1'b0;
            packed_q.push_back(res);
        end
        acc = acc & ((17'd1 << n) - 17'd1);
        if (item.last_byte) begin
            if (n > 0) begin
                fill = pad_cfg ? 8'((9'd1 << (8 - n)) - 9'd1) : 8'h00;
                res.out_byte = 8'(acc << (8 - n)) | fill;
                res.out_last = 1'b1;
                packed_q.push_back(res);
            end else begin
                packed_q[packed_q.size()-1].out_last = 1'b1;
            end
            held_bits  = '0;
            held_count = 0;
        end else begin
            held_bits  = acc[6:0];
            held_count = n;
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        in_item_t item;
        int       gap;
        gap = pick_gap();
        item.data_byte = data;
        item.last_byte = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pack_frame(item);
    endtask

    task automatic send_buffer(input int len);
        int          i;
        int          r;
        logic [7:0]  data;
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) data = 8'h00;
            else if (r == 1) data = 8'hFF;
            else data = 8'($urandom_range(0, 255));
            send_byte(data, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (packed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PAD_BIT) pad_cfg = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    // pad at reset value; single-byte buffers and a buffer ending on a byte boundary
    task automatic test_reset_pad();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        wait_idle();
    endtask

    // pad 0, written with junk in the upper bits; lengths hit every leftover count
    task automatic test_pad_zero();
        int len;
        apb_write(ADDR_PAD_BIT, 32'hFFFF_FFFE);
        for (len = 1; len <= 5; len++) begin
            send_buffer(len);
        end
        wait_idle();
    endtask

    task automatic test_burst();
        int sent;
        int len;
        sent = 0;
        apb_write(ADDR_PAD_BIT, 32'h8000_0001);
        burst_mode = 1'b1;
        while (sent < 60) begin
            len = pick_length();
            send_buffer(len);
            sent += len;
        end
        wait_idle();
        burst_mode = 1'b0;
    endtask

    task automatic test_random();
        int phase;
        int sent;
        int len;
        for (phase = 0; phase < 4; phase++) begin
            apb_write(ADDR_PAD_BIT, {31'($urandom_range(0, 32'h7FFF_FFFF)), phase[0]});
            sent = 0;
            while (sent < 85) begin
                len = pick_length();
                send_buffer(len);
                sent += len;
            end
            wait_idle();
        end
    endtask

    initial begin : rx_side
        int run;
        int gap;
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (packed_q.size() == 0) begin
                report_mismatch("unexpected byte", int'(m_data.out_byte), 0);
            end else begin
                want_item = packed_q.pop_front();
                if (m_data.out_byte !== want_item.out_byte)
                    report_mismatch("out_byte", int'(m_data.out_byte),
                                    int'(want_item.out_byte));
                if (m_data.out_last !== want_item.out_last)
                    report_mismatch("out_last", int'(m_data.out_last),
                                    int'(want_item.out_last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_pad();
        test_pad_zero();
        test_burst();
        test_random();
        wait_idle();
        if (packed_q.size() != 0)
            report_mismatch("bytes never emitted", 0, packed_q.size());
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
